[sv/brs_pkg.sv]
// Shared constants, types and helpers for the bilinear RGB sampler.
package brs_pkg;

  // Store geometry and fixed point format
  localparam int MAX_ROWS    = 512;
  localparam int MAX_COLS    = 512;
  localparam int FRAC_BITS   = 9;
  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int ROW_DIM_W   = $clog2(MAX_ROWS + 1);
  localparam int COL_DIM_W   = $clog2(MAX_COLS + 1);

  // Field widths of the item channels
  localparam int CFG_W     = 10;
  localparam int PIX_W     = 24;
  localparam int CH_W      = 8;
  localparam int NUM_CH    = 3;
  localparam int COORD_W   = 9;
  localparam int FFRAC_W   = 9;
  localparam int IDX_W     = 18;
  localparam int WADDR_W   = 18;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;

  // Weight holds 0..2^FRAC_BITS, accumulator holds the sum of four weighted channel values
  localparam int WGT_W     = FRAC_BITS + 1;
  localparam int ACC_W     = WGT_W + CH_W + 2;
  localparam int CMP_W     = 16;
  localparam int BASE_W    = COORD_W + ROW_DIM_W + 1;

  localparam logic [CFG_W-1:0] ROWS_RESET = CFG_W'(512);
  localparam logic [CFG_W-1:0] COLS_RESET = CFG_W'(512);

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef enum logic {
    REG_ROWS = 1'b0,
    REG_COLS = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_RD0,
    S_RD1,
    S_RD2,
    S_RD3,
    S_LAST,
    S_FIN
  } state_t;

  // Sequencer to blend unit
  typedef struct packed {
    logic       clear;
    logic       wgt_load;
    logic [1:0] wgt_sel;
    logic       mac_en;
  } blend_ctl_t;

  function automatic logic [ROW_DIM_W-1:0] clamp_rows(input logic [CFG_W-1:0] v);
    logic [ROW_DIM_W-1:0] res;
    if (32'(v) < 2) res = ROW_DIM_W'(2);
    else if (32'(v) > MAX_ROWS) res = ROW_DIM_W'(MAX_ROWS);
    else res = ROW_DIM_W'(v);
    return res;
  endfunction

  function automatic logic [COL_DIM_W-1:0] clamp_cols(input logic [CFG_W-1:0] v);
    logic [COL_DIM_W-1:0] res;
    if (32'(v) < 2) res = COL_DIM_W'(2);
    else if (32'(v) > MAX_COLS) res = COL_DIM_W'(MAX_COLS);
    else res = COL_DIM_W'(v);
    return res;
  endfunction

endpackage

[sv/brs_image_ram.sv]
// Simple dual-port image store: one write port, one registered read port.
module brs_image_ram #(
  parameter int AW    = 18,
  parameter int DW    = 24,
  parameter int DEPTH = 262144
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/brs_blend.sv]
// Weight generation and per-channel multiply-accumulate over four neighbours.
module brs_blend (
  input  logic                          clk,
  input  brs_pkg::blend_ctl_t           ctl,
  input  logic [brs_pkg::FRAC_BITS-1:0] frac_x,
  input  logic [brs_pkg::FRAC_BITS-1:0] frac_y,
  input  logic [brs_pkg::PIX_W-1:0]     pix,
  output logic [brs_pkg::CH_W-1:0]      red,
  output logic [brs_pkg::CH_W-1:0]      green,
  output logic [brs_pkg::CH_W-1:0]      blue
);
  import brs_pkg::*;

  localparam logic [WGT_W-1:0] ONE    = WGT_W'(1) << FRAC_BITS;
  localparam int               SUM_W  = ACC_W - FRAC_BITS;
  localparam logic [SUM_W-1:0] CH_MAX = SUM_W'((1 << CH_W) - 1);

  logic [WGT_W-1:0]   fa;
  logic [WGT_W-1:0]   fb;
  logic [2*WGT_W-1:0] wprod;
  logic [WGT_W-1:0]   wgt_nxt;
  logic [WGT_W-1:0]   wgt_r;
  logic [ACC_W-1:0]   acc_r [NUM_CH];
  logic [CH_W-1:0]    chan  [NUM_CH];
  logic [SUM_W-1:0]   sum   [NUM_CH];
  logic [CH_W-1:0]    sat   [NUM_CH];

  // weight for neighbour: bit 0 picks fx or 1-fx, bit 1 picks fy or 1-fy
  always_comb begin
    fa      = ctl.wgt_sel[0] ? WGT_W'(frac_x) : ONE - WGT_W'(frac_x);
    fb      = ctl.wgt_sel[1] ? WGT_W'(frac_y) : ONE - WGT_W'(frac_y);
    wprod   = (2*WGT_W)'(fa) * (2*WGT_W)'(fb);
    wgt_nxt = wprod[FRAC_BITS +: WGT_W];
  end

  always_ff @(posedge clk) begin
    if (ctl.wgt_load) begin
      wgt_r <= wgt_nxt;
    end
  end

  // channel lanes, red in the top byte
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      chan[c] = pix[PIX_W - CH_W*(c+1) +: CH_W];
    end
  end

  // accumulate weighted channels
  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_CH; c++) begin
      if (ctl.clear) begin
        acc_r[c] <= '0;
      end else if (ctl.mac_en) begin
        acc_r[c] <= acc_r[c] + ACC_W'(ACC_W'(wgt_r) * ACC_W'(chan[c]));
      end
    end
  end

  // floor and saturate
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      sum[c] = acc_r[c][FRAC_BITS +: SUM_W];
      sat[c] = (sum[c] > CH_MAX) ? CH_W'(CH_MAX) : CH_W'(sum[c]);
    end
  end

  assign red   = sat[0];
  assign green = sat[1];
  assign blue  = sat[2];

endmodule

[sv/bilinear_rgb_fixed_point_sampler.sv]
// Top level: APB registers, item sequencer, image store and output register.
//
//  channel   direction  handshake              payload
//  in_       input      in_valid / in_stall    opcode, write_address, write_rgb, base,
//                                              frac, dest_index
//  out_      output     out_valid / out_stall  red, green, blue, index, in_range
//  APB       input      psel/penable/pready    paddr, pwdata, prdata
//
// A write item goes into the store at the edge it is accepted. A sample item
// steps S_PREP, S_RD0..S_RD3, S_LAST, S_FIN (or S_PREP, S_FIN if a neighbour is off
// the image): the four neighbours come one per cycle through the single read port of
// the store. Reset sets both dimension registers to 512; the store is not cleared.
// A finished result sits in the output register; the next item is taken while it
// waits, and a sample only holds in its final cycle if the previous result is
// still there.
module bilinear_rgb_fixed_point_sampler (
  input  logic                        clk,
  input  logic                        rst_n,
  // input items
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_opcode,
  input  logic [brs_pkg::WADDR_W-1:0] in_write_address,
  input  logic [brs_pkg::PIX_W-1:0]   in_write_rgb,
  input  logic [brs_pkg::COORD_W-1:0] in_base_x,
  input  logic [brs_pkg::COORD_W-1:0] in_base_y,
  input  logic [brs_pkg::FFRAC_W-1:0] in_frac_x,
  input  logic [brs_pkg::FFRAC_W-1:0] in_frac_y,
  input  logic [brs_pkg::IDX_W-1:0]   in_dest_index,
  // result items
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [brs_pkg::CH_W-1:0]    out_red,
  output logic [brs_pkg::CH_W-1:0]    out_green,
  output logic [brs_pkg::CH_W-1:0]    out_blue,
  output logic [brs_pkg::IDX_W-1:0]   out_index,
  output logic                        out_in_range,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [brs_pkg::APB_AW-1:0]  paddr,
  input  logic [brs_pkg::APB_DW-1:0]  pwdata,
  output logic [brs_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import brs_pkg::*;

  state_t                 state_r, state_nxt;
  logic [CFG_W-1:0]       rows_cfg_r, cols_cfg_r;
  logic [ROW_DIM_W-1:0]   rows_eff;
  logic [COL_DIM_W-1:0]   cols_eff;
  logic                   cfg_wr;
  reg_idx_t               cfg_sel;

  logic                   in_acc;
  logic                   ram_we;
  logic                   ram_re;
  logic [ADDR_W-1:0]      ram_raddr;
  logic [PIX_W-1:0]       ram_rdata;

  logic [COORD_W-1:0]     bx_r, by_r;
  logic [FRAC_BITS-1:0]   fx_r, fy_r;
  logic [IDX_W-1:0]       idx_r;
  logic [ADDR_W-1:0]      base_r;
  logic [ADDR_W-1:0]      rows_off_r;
  logic                   range_r;

  logic                   range_ok;
  logic [BASE_W-1:0]      base_full;
  logic                   out_load;
  blend_ctl_t             bctl;
  logic [CH_W-1:0]        b_red, b_green, b_blue;

  logic                   out_valid_r;
  logic [CH_W-1:0]        out_red_r, out_green_r, out_blue_r;
  logic [IDX_W-1:0]       out_index_r;
  logic                   out_in_range_r;

  // APB registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_sel = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= ROWS_RESET;
      cols_cfg_r <= COLS_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_ROWS: rows_cfg_r <= pwdata[CFG_W-1:0];
        REG_COLS: cols_cfg_r <= pwdata[CFG_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_ROWS: prdata = APB_DW'(rows_cfg_r);
      REG_COLS: prdata = APB_DW'(cols_cfg_r);
      default:  prdata = '0;
    endcase
  end

  assign rows_eff = clamp_rows(rows_cfg_r);
  assign cols_eff = clamp_cols(cols_cfg_r);

  // input handshake; writes go straight to the store
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid & ~in_stall;
  assign ram_we   = in_acc && (op_t'(in_opcode) == OP_WRITE)
                    && (32'(in_write_address) < STORE_DEPTH);

  // capture sample item
  always_ff @(posedge clk) begin
    if (in_acc && op_t'(in_opcode) == OP_SAMPLE) begin
      bx_r  <= in_base_x;
      by_r  <= in_base_y;
      fx_r  <= FRAC_BITS'(in_frac_x);
      fy_r  <= FRAC_BITS'(in_frac_y);
      idx_r <= in_dest_index;
    end
  end

  // range check and top-left store address
  always_comb begin
    range_ok  = (CMP_W'(bx_r) + CMP_W'(1) < CMP_W'(cols_eff))
                && (CMP_W'(by_r) + CMP_W'(1) < CMP_W'(rows_eff));
    base_full = BASE_W'(bx_r) * BASE_W'(rows_eff) + BASE_W'(by_r);
  end

  always_ff @(posedge clk) begin
    if (state_r == S_PREP) begin
      base_r     <= ADDR_W'(base_full);
      rows_off_r <= ADDR_W'(rows_eff);
      range_r    <= range_ok;
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign out_load = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  // next state, neighbour fetch and blend control
  always_comb begin
    state_nxt = state_r;
    ram_re    = 1'b0;
    ram_raddr = base_r;
    bctl      = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && op_t'(in_opcode) == OP_SAMPLE) state_nxt = S_PREP;
      end
      S_PREP: begin
        bctl.clear = 1'b1;
        state_nxt  = range_ok ? S_RD0 : S_FIN;
      end
      S_RD0: begin
        ram_re        = 1'b1;
        ram_raddr     = base_r;
        bctl.wgt_load = 1'b1;
        bctl.wgt_sel  = 2'd0;
        state_nxt     = S_RD1;
      end
      S_RD1: begin
        ram_re        = 1'b1;
        ram_raddr     = base_r + rows_off_r;
        bctl.wgt_load = 1'b1;
        bctl.wgt_sel  = 2'd1;
        bctl.mac_en   = 1'b1;
        state_nxt     = S_RD2;
      end
      S_RD2: begin
        ram_re        = 1'b1;
        ram_raddr     = base_r + ADDR_W'(1);
        bctl.wgt_load = 1'b1;
        bctl.wgt_sel  = 2'd2;
        bctl.mac_en   = 1'b1;
        state_nxt     = S_RD3;
      end
      S_RD3: begin
        ram_re        = 1'b1;
        ram_raddr     = base_r + rows_off_r + ADDR_W'(1);
        bctl.wgt_load = 1'b1;
        bctl.wgt_sel  = 2'd3;
        bctl.mac_en   = 1'b1;
        state_nxt     = S_LAST;
      end
      S_LAST: begin
        bctl.mac_en = 1'b1;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  brs_image_ram #(
    .AW    (ADDR_W),
    .DW    (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(in_write_address)),
    .wdata (in_write_rgb),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  brs_blend u_blend (
    .clk    (clk),
    .ctl    (bctl),
    .frac_x (fx_r),
    .frac_y (fy_r),
    .pix    (ram_rdata),
    .red    (b_red),
    .green  (b_green),
    .blue   (b_blue)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_red_r      <= range_r ? b_red   : '0;
      out_green_r    <= range_r ? b_green : '0;
      out_blue_r     <= range_r ? b_blue  : '0;
      out_index_r    <= idx_r;
      out_in_range_r <= range_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_red      = out_red_r;
  assign out_green    = out_green_r;
  assign out_blue     = out_blue_r;
  assign out_index    = out_index_r;
  assign out_in_range = out_in_range_r;

  // store is only written while no neighbour fetch is in flight
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == S_IDLE)
    else $error("store write during sample");

  // an accepted sample blocks the input on the next cycle
  a_sample_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && op_t'(in_opcode) == OP_SAMPLE |=> in_stall)
    else $error("sample did not block input");

  // a result only appears out of the final sequencer step
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FIN)
    else $error("result without sample");

  // out-of-range results carry zero colour
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_in_range_r |-> out_red_r == '0 && out_green_r == '0
      && out_blue_r == '0)
    else $error("colour on out-of-range result");

endmodule

[verif/tb_bilinear_rgb_fixed_point_sampler.sv]
// Self-checking testbench for the bilinear RGB sampler: directed table, then random phases.
`timescale 1ns / 100ps

module tb_bilinear_rgb_fixed_point_sampler;
  import brs_pkg::*;

  localparam int STORE_N     = 262144;
  localparam int ONE_W       = 1 << FRAC_BITS;
  localparam int WD_LIMIT    = 5000;
  localparam int N_DIRECTED  = 18;
  localparam int N_PHASES    = 8;
  localparam int PHASE_ITEMS = 115;

  // one interpolated pixel as it leaves the block
  typedef struct packed {
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic [IDX_W-1:0] index;
    logic             in_range;
  } pix_result_t;

  // one input item, with an optional hand-written expectation
  typedef struct packed {
    op_t                op;
    logic [WADDR_W-1:0] waddr;
    logic [PIX_W-1:0]   rgb;
    logic [COORD_W-1:0] bx;
    logic [COORD_W-1:0] by;
    logic [FFRAC_W-1:0] fx;
    logic [FFRAC_W-1:0] fy;
    logic [IDX_W-1:0]   idx;
    logic               typed;
    logic [CH_W-1:0]    t_red;
    logic [CH_W-1:0]    t_green;
    logic [CH_W-1:0]    t_blue;
    logic               t_in_range;
  } stim_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_opcode;
  logic [WADDR_W-1:0]  in_write_address;
  logic [PIX_W-1:0]    in_write_rgb;
  logic [COORD_W-1:0]  in_base_x;
  logic [COORD_W-1:0]  in_base_y;
  logic [FFRAC_W-1:0]  in_frac_x;
  logic [FFRAC_W-1:0]  in_frac_y;
  logic [IDX_W-1:0]    in_dest_index;
  logic                out_valid;
  logic                out_stall;
  logic [CH_W-1:0]     out_red;
  logic [CH_W-1:0]     out_green;
  logic [CH_W-1:0]     out_blue;
  logic [IDX_W-1:0]    out_index;
  logic                out_in_range;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  // shadow image and dimensions
  logic [PIX_W-1:0]    image_copy [0:STORE_N-1];
  bit                  pixel_written [0:STORE_N-1];
  int                  rows_eff;
  int                  cols_eff;

  pix_result_t         pending_pixels [$];
  pix_result_t         head_pixel;
  int                  err_count;
  int                  items_sent;
  int                  idle_cycles;
  int                  send_idle;
  int                  recv_stall;

  // settings per phase; phase 0 runs on reset values
  int rows_cfg [N_PHASES] = '{512, 2, 0, 1023, 513, 7, 300, 16};
  int cols_cfg [N_PHASES] = '{512, 2, 1, 1023, 600, 300, 5, 16};

  // directed items, all at reset dimensions (512 x 512)
  stim_row_t directed_rows [N_DIRECTED] = '{
    // out of range straight after reset, no store read
    '{OP_SAMPLE, 18'd0, 24'h0, 9'd511, 9'd511, 9'd0, 9'd0, 18'd0, 1'b1, 8'd0, 8'd0, 8'd0, 1'b0},
    '{OP_WRITE, 18'd0, 24'hFFFFFF, 9'd0, 9'd0, 9'd0, 9'd0, 18'd0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{OP_WRITE, 18'd1, 24'h000000, 9'd0, 9'd0, 9'd0, 9'd0, 18'd0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{OP_WRITE, 18'd512, 24'hFF00FF, 9'd0, 9'd0, 9'd0, 9'd0, 18'd0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{OP_WRITE, 18'd513, 24'h00FF00, 9'd0, 9'd0, 9'd0, 9'd0, 18'd0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
    // zero fractions: the top-left neighbour alone
    '{OP_SAMPLE, 18'd0, 24'h0, 9'd0, 9'd0, 9'd0, 9'd0, 18'h3FFFF,
      1'b1, 8'd255, 8'd255, 8'd255, 1'b1},
    '{OP_SAMPLE, 18'd0, 24'h0, 9'd0, 9'd0, 9'd511, 9'd0, 18'd1, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{OP_SAMPLE, 18'd0, 24'h0, 9'd0, 9'd0, 9'd0, 9'd511, 18'd2, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{OP_SAMPLE, 18'd0, 24'h0, 9'd0, 9'd0, 9'd511, 9'd511, 18'd3, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{OP_SAMPLE, 18'd0, 24'h0, 9'd0, 9'd0, 9'h155, 9'h0AA, 18'h2AAAA,
      1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{OP_SAMPLE, 18'd0, 24'h0, 9'd0, 9'd0, 9'h0AA, 9'h155, 18'h15555,
      1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
    // far corner of the store, top address included
    '{OP_WRITE, 18'd261630, 24'h123456, 9'd0, 9'd0, 9'd0, 9'd0, 18'd0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{OP_WRITE, 18'd261631, 24'hFEDCBA, 9'd0, 9'd0, 9'd0, 9'd0, 18'd0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{OP_WRITE, 18'd262142, 24'hA5A5A5, 9'd0, 9'd0, 9'd0, 9'd0, 18'd0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{OP_WRITE, 18'h3FFFF, 24'h5A5A5A, 9'd0, 9'd0, 9'd0, 9'd0, 18'd0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{OP_SAMPLE, 18'd0, 24'h0, 9'd510, 9'd510, 9'd256, 9'd256, 18'h1FFFF,
      1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
    // bottom neighbour one row past the image
    '{OP_SAMPLE, 18'd0, 24'h0, 9'd510, 9'd511, 9'd7, 9'd9, 18'd5, 1'b1, 8'd0, 8'd0, 8'd0, 1'b0},
    // right neighbour one column past the image
    '{OP_SAMPLE, 18'd0, 24'h0, 9'd511, 9'd0, 9'd511, 9'd511, 18'h3FFFF,
      1'b1, 8'd0, 8'd0, 8'd0, 1'b0}
  };

  bilinear_rgb_fixed_point_sampler u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_write_address (in_write_address),
    .in_write_rgb     (in_write_rgb),
    .in_base_x        (in_base_x),
    .in_base_y        (in_base_y),
    .in_frac_x        (in_frac_x),
    .in_frac_y        (in_frac_y),
    .in_dest_index    (in_dest_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_index        (out_index),
    .out_in_range     (out_in_range),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // saturate a dimension register to what the block actually uses
  function automatic int dim_eff(input int v, input int maxv);
    if (v < 2) return 2;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // column-major store address at the current row count
  function automatic int px_addr(input int x, input int y);
    return x * rows_eff + y;
  endfunction

  // bilinear blend of the four neighbours, weights floored to FRAC_BITS
  function automatic pix_result_t blend_sample(input logic [COORD_W-1:0] bx,
                                               input logic [COORD_W-1:0] by,
                                               input logic [FFRAC_W-1:0] fx,
                                               input logic [FFRAC_W-1:0] fy,
                                               input logic [IDX_W-1:0] idx);
    pix_result_t r;
    int fxi;
    int fyi;
    int w [4];
    int a [4];
    int sum;
    logic [PIX_W-1:0] px;
    logic [CH_W-1:0] chan [3];
    r = '0;
    r.index = idx;
    if (int'(bx) + 1 >= cols_eff || int'(by) + 1 >= rows_eff) return r;
    fxi = int'(fx) & (ONE_W - 1);
    fyi = int'(fy) & (ONE_W - 1);
    w[0] = ((ONE_W - fyi) * (ONE_W - fxi)) >> FRAC_BITS;
    w[1] = ((ONE_W - fyi) * fxi) >> FRAC_BITS;
    w[2] = (fyi * (ONE_W - fxi)) >> FRAC_BITS;
    w[3] = (fyi * fxi) >> FRAC_BITS;
    a[0] = px_addr(int'(bx), int'(by));
    a[1] = px_addr(int'(bx) + 1, int'(by));
    a[2] = px_addr(int'(bx), int'(by) + 1);
    a[3] = px_addr(int'(bx) + 1, int'(by) + 1);
    for (int c = 0; c < 3; c++) begin
      sum = 0;
      for (int k = 0; k < 4; k++) begin
        px = image_copy[a[k]];
        sum += w[k] * int'(px[16 - 8 * c +: 8]);
      end
      sum = sum >> FRAC_BITS;
      if (sum > 255) sum = 255;
      chan[c] = CH_W'(sum);
    end
    r.red = chan[0];
    r.green = chan[1];
    r.blue = chan[2];
    r.in_range = 1'b1;
    return r;
  endfunction

  function automatic logic [PIX_W-1:0] rand_rgb();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom());
    endcase
  endfunction

  function automatic logic [FFRAC_W-1:0] rand_frac();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return FFRAC_W'($urandom());
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [IDX_W-1:0] want,
                                      input logic [IDX_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      err_count++;
    end
  endfunction

  // present one item from a falling edge, hold it until taken, then predict
  task automatic send_item(input stim_row_t it);
    pix_result_t want;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_opcode        <= it.op;
    in_write_address <= it.waddr;
    in_write_rgb     <= it.rgb;
    in_base_x        <= it.bx;
    in_base_y        <= it.by;
    in_frac_x        <= it.fx;
    in_frac_y        <= it.fy;
    in_dest_index    <= it.idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (it.op == OP_WRITE) begin
      image_copy[it.waddr] = it.rgb;
      pixel_written[it.waddr] = 1'b1;
    end else begin
      if (it.typed) want = '{it.t_red, it.t_green, it.t_blue, it.idx, it.t_in_range};
      else want = blend_sample(it.bx, it.by, it.fx, it.fy, it.idx);
      pending_pixels.insert(pending_pixels.size(), want);
    end
    items_sent++;
    @(negedge clk);
  endtask

  // stop sending and wait for every outstanding pixel
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_pixels.size() != 0) @(negedge clk);
  endtask

  // register write then read-back; block is idle here
  task automatic cfg_write(input reg_idx_t ri, input logic [CFG_W-1:0] v);
    logic [APB_DW-1:0] word;
    logic [APB_DW-1:0] got;
    word = $urandom();
    word[CFG_W-1:0] = v;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(4 * int'(ri));
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== APB_DW'(v)) begin
      $display("%0t: register %s read-back, expected %0h, got %0h", $time, ri.name(), v, got);
      err_count++;
    end
    if (ri == REG_ROWS) rows_eff = dim_eff(int'(v), MAX_ROWS);
    else cols_eff = dim_eff(int'(v), MAX_COLS);
  endtask

  // random items: mostly in-image samples with their neighbours written first
  task automatic run_phase(input int target);
    stim_row_t r;
    stim_row_t wr;
    int start;
    int pick;
    int a;
    start = items_sent;
    while (items_sent - start < target) begin
      if ($urandom_range(39) == 0) drain_results();
      r = '0;
      pick = $urandom_range(99);
      if (pick < 20) begin
        r.op = OP_WRITE;
        r.rgb = rand_rgb();
        if (pick < 10) r.waddr = WADDR_W'($urandom());
        else r.waddr = WADDR_W'(px_addr($urandom_range(cols_eff - 1),
                                       $urandom_range(rows_eff - 1)));
        send_item(r);
      end else begin
        r.op = OP_SAMPLE;
        r.fx = rand_frac();
        r.fy = rand_frac();
        r.idx = IDX_W'($urandom());
        if (pick < 32) begin
          // noise: anywhere in the coordinate range, on or off the image
          r.bx = COORD_W'($urandom());
          r.by = COORD_W'($urandom());
        end else begin
          r.bx = COORD_W'($urandom_range(cols_eff - 2));
          r.by = COORD_W'($urandom_range(rows_eff - 2));
        end
        if (int'(r.bx) + 1 < cols_eff && int'(r.by) + 1 < rows_eff) begin
          for (int k = 0; k < 4; k++) begin
            a = px_addr(int'(r.bx) + k % 2, int'(r.by) + k / 2);
            if (!pixel_written[a] || $urandom_range(9) == 0) begin
              wr = '0;
              wr.op = OP_WRITE;
              wr.waddr = WADDR_W'(a);
              wr.rgb = rand_rgb();
              send_item(wr);
            end
          end
        end
        send_item(r);
      end
    end
  endtask

  // receiver stall, redrawn each cycle
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall);
  end

  // result check against the oldest expected pixel
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel, expected none, got index %0h rgb %0h%0h%0h",
                 $time, out_index, out_red, out_green, out_blue);
        err_count++;
      end else begin
        head_pixel = pending_pixels.pop_front();
        check_field("red", IDX_W'(head_pixel.red), IDX_W'(out_red));
        check_field("green", IDX_W'(head_pixel.green), IDX_W'(out_green));
        check_field("blue", IDX_W'(head_pixel.blue), IDX_W'(out_blue));
        check_field("index", head_pixel.index, out_index);
        check_field("in_range", IDX_W'(head_pixel.in_range), IDX_W'(out_in_range));
      end
    end
  end

  // watchdog on cycles with no transfer anywhere
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WD_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WD_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_opcode        = OP_WRITE;
    in_write_address = '0;
    in_write_rgb     = '0;
    in_base_x        = '0;
    in_base_y        = '0;
    in_frac_x        = '0;
    in_frac_y        = '0;
    in_dest_index    = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    err_count        = 0;
    items_sent       = 0;
    idle_cycles      = 0;
    send_idle        = 0;
    recv_stall       = 0;
    rows_eff         = MAX_ROWS;
    cols_eff         = MAX_COLS;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) send_item(directed_rows[i]);

    for (int p = 0; p < N_PHASES; p++) begin
      // idle pattern: none, sender, receiver, both
      case (p % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 59; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 59; end
        default: begin send_idle = 15; recv_stall = 15; end
      endcase
      if (p > 0) begin
        drain_results();
        repeat (12) @(negedge clk);
        cfg_write(REG_ROWS, CFG_W'(rows_cfg[p]));
        cfg_write(REG_COLS, CFG_W'(cols_cfg[p]));
      end
      run_phase(PHASE_ITEMS);
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (err_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
